FILE: src/hsvr_pkg.sv
`timescale 1ns / 1ps
// hsvr_pkg: shared types and constants for the rainbow hsv to rgb pipeline
// no dependencies; imported by every module of the block

package hsvr_pkg;

	localparam int unsigned ChW = 8;

	localparam logic [ChW-1:0] ChMax     = 8'd255;
	localparam logic [ChW-1:0] ThirdK    = 8'(256 / 3);
	localparam logic [ChW-1:0] TwoThirdK = 8'((256 * 2) / 3);
	localparam logic [ChW-1:0] Lvl85     = 8'd85;
	localparam logic [ChW-1:0] Lvl170    = 8'd170;
	localparam logic [ChW-1:0] Lvl171    = 8'd171;
	localparam logic [4:0]     OffMask   = 5'h1F;

	typedef enum logic [2:0] {
		SEC_RED_ORANGE,
		SEC_ORANGE_YELLOW,
		SEC_YELLOW_GREEN,
		SEC_GREEN_AQUA,
		SEC_AQUA_BLUE,
		SEC_BLUE_PURPLE,
		SEC_PURPLE_PINK,
		SEC_PINK_RED
	} sect_t;

	typedef struct packed {
		logic [ChW-1:0] r;
		logic [ChW-1:0] g;
		logic [ChW-1:0] b;
	} rgb_t;

	typedef struct packed {
		logic           s_full;
		logic           s_zero;
		logic           v_full;
		logic           v_zero;
		logic [ChW-1:0] satscale;
		logic [ChW-1:0] sat_floor;
		logic [ChW-1:0] vscale;
	} ctl_t;

	function automatic logic [ChW-1:0] mul_hi(input logic [ChW-1:0] a, input logic [ChW-1:0] b);
		logic [2*ChW-1:0] p;
		p = a * b;
		return p[2*ChW-1:ChW];
	endfunction

endpackage

FILE: src/hsvr_prep.sv
`timescale 1ns / 1ps
// hsvr_prep: stage 1, hue offset scaling and saturation / brightness scale factors
// depends on hsvr_pkg

module hsvr_prep (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     valid_in,
	input  logic [7:0]               hue,
	input  logic [7:0]               saturation,
	input  logic [7:0]               brightness,
	output logic                     valid_s1,
	output hsvr_pkg::sect_t          sect_s1,
	output logic [7:0]               third_s1,
	output logic [7:0]               twothirds_s1,
	output hsvr_pkg::ctl_t           ctl_s1
);
	import hsvr_pkg::*;

	logic [ChW-1:0] step8;
	logic [ChW-1:0] desat;
	logic [ChW-1:0] desat_sq;
	ctl_t           ctl_d;

	assign step8    = {hue[4:0] & OffMask, 3'b000};
	assign desat    = ChMax - saturation;
	assign desat_sq = mul_hi(desat, desat);

	always_comb begin
		ctl_d.s_full    = (saturation == ChMax);
		ctl_d.s_zero    = (saturation == '0);
		ctl_d.v_full    = (brightness == ChMax);
		ctl_d.v_zero    = (brightness == '0);
		ctl_d.satscale  = ChMax - desat_sq;
		ctl_d.sat_floor = desat_sq;
		ctl_d.vscale    = mul_hi(brightness, brightness);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		sect_s1      <= sect_t'(hue[7:5]);
		third_s1     <= mul_hi(step8, ThirdK);
		twothirds_s1 <= mul_hi(step8, TwoThirdK);
		ctl_s1       <= ctl_d;
	end

endmodule

FILE: src/hsvr_hue.sv
`timescale 1ns / 1ps
// hsvr_hue: stage 2, base rainbow colour from hue section and offset
// depends on hsvr_pkg

module hsvr_hue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  hsvr_pkg::sect_t sect_s1,
	input  logic [7:0]      third_s1,
	input  logic [7:0]      twothirds_s1,
	input  hsvr_pkg::ctl_t  ctl_s1,
	output logic            valid_s2,
	output hsvr_pkg::rgb_t  rgb_s2,
	output hsvr_pkg::ctl_t  ctl_s2
);
	import hsvr_pkg::*;

	rgb_t base;

	always_comb begin
		base = '0;
		case (sect_s1)
			SEC_RED_ORANGE: begin
				base.r = ChMax - third_s1;
				base.g = third_s1;
			end
			SEC_ORANGE_YELLOW: begin
				base.r = Lvl171;
				base.g = Lvl85 + third_s1;
			end
			SEC_YELLOW_GREEN: begin
				base.r = Lvl171 - twothirds_s1;
				base.g = Lvl170 + third_s1;
			end
			SEC_GREEN_AQUA: begin
				base.g = ChMax - third_s1;
				base.b = third_s1;
			end
			SEC_AQUA_BLUE: begin
				base.g = Lvl171 - twothirds_s1;
				base.b = Lvl85 + twothirds_s1;
			end
			SEC_BLUE_PURPLE: begin
				base.r = third_s1;
				base.b = ChMax - third_s1;
			end
			SEC_PURPLE_PINK: begin
				base.r = Lvl85 + third_s1;
				base.b = Lvl171 - third_s1;
			end
			SEC_PINK_RED: begin
				base.r = Lvl170 + third_s1;
				base.b = Lvl85 - third_s1;
			end
			default: begin
				base = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s2 <= base;
		ctl_s2 <= ctl_s1;
	end

endmodule

FILE: src/hsvr_sat.sv
`timescale 1ns / 1ps
// hsvr_sat: stage 3, blend toward white by saturation, one multiplier per channel
// depends on hsvr_pkg

module hsvr_sat (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s2,
	input  hsvr_pkg::rgb_t rgb_s2,
	input  hsvr_pkg::ctl_t ctl_s2,
	output logic           valid_s3,
	output hsvr_pkg::rgb_t rgb_s3,
	output hsvr_pkg::ctl_t ctl_s3
);
	import hsvr_pkg::*;

	rgb_t sat;

	function automatic logic [ChW-1:0] desat_ch(input logic [ChW-1:0] c,
			input logic [ChW-1:0] scale, input logic [ChW-1:0] flr);
		logic [ChW-1:0] m;
		m = (c != '0) ? mul_hi(c, scale) + 8'd1 : '0;
		return m + flr;
	endfunction

	always_comb begin
		if (ctl_s2.s_full) begin
			sat = rgb_s2;
		end else if (ctl_s2.s_zero) begin
			sat = {ChMax, ChMax, ChMax};
		end else begin
			sat.r = desat_ch(rgb_s2.r, ctl_s2.satscale, ctl_s2.sat_floor);
			sat.g = desat_ch(rgb_s2.g, ctl_s2.satscale, ctl_s2.sat_floor);
			sat.b = desat_ch(rgb_s2.b, ctl_s2.satscale, ctl_s2.sat_floor);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s3 <= sat;
		ctl_s3 <= ctl_s2;
	end

endmodule

FILE: src/hsvr_val.sv
`timescale 1ns / 1ps
// hsvr_val: stage 4, brightness dimming with the squared value curve
// depends on hsvr_pkg

module hsvr_val (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           valid_s3,
	input  hsvr_pkg::rgb_t rgb_s3,
	input  hsvr_pkg::ctl_t ctl_s3,
	output logic           valid_s4,
	output hsvr_pkg::rgb_t rgb_s4
);
	import hsvr_pkg::*;

	rgb_t dim;

	function automatic logic [ChW-1:0] dim_ch(input logic [ChW-1:0] c,
			input logic [ChW-1:0] scale);
		return (c != '0) ? mul_hi(c, scale) + 8'd1 : '0;
	endfunction

	always_comb begin
		if (ctl_s3.v_full) begin
			dim = rgb_s3;
		end else if (ctl_s3.v_zero) begin
			dim = '0;
		end else begin
			dim.r = dim_ch(rgb_s3.r, ctl_s3.vscale);
			dim.g = dim_ch(rgb_s3.g, ctl_s3.vscale);
			dim.b = dim_ch(rgb_s3.b, ctl_s3.vscale);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		rgb_s4 <= dim;
	end

endmodule

FILE: src/hsv_rainbow_to_rgb.sv
`timescale 1ns / 1ps
// hsv_rainbow_to_rgb: top level of the four-stage rainbow hsv to rgb converter
// depends on hsvr_pkg, hsvr_prep, hsvr_hue, hsvr_sat, hsvr_val
//
//  channel   ports                          marker
//  command   hue, saturation, brightness    start (taken while busy is low)
//  result    red, green, blue               done (one cycle, always taken)
//
// a word taken at a start edge passes the prep, hue, sat and val registers in turn
// before it shows on the result ports; these four register stages set the latency
// one word per cycle sustained
// busy is held low, the receiver never stalls so no word ever waits
// arst_n clears the stage valid bits only; payload registers are not reset

module hsv_rainbow_to_rgb (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [7:0] hue,
	input  logic [7:0] saturation,
	input  logic [7:0] brightness,
	output logic       done,
	output logic [7:0] red,
	output logic [7:0] green,
	output logic [7:0] blue
);
	import hsvr_pkg::*;

	logic  valid_s1;
	logic  valid_s2;
	logic  valid_s3;
	logic  valid_s4;
	sect_t sect_s1;
	logic  [7:0] third_s1;
	logic  [7:0] twothirds_s1;
	ctl_t  ctl_s1;
	ctl_t  ctl_s2;
	ctl_t  ctl_s3;
	rgb_t  rgb_s2;
	rgb_t  rgb_s3;
	rgb_t  rgb_s4;

	assign busy = 1'b0;

	hsvr_prep u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_in     (start & ~busy),
		.hue          (hue),
		.saturation   (saturation),
		.brightness   (brightness),
		.valid_s1     (valid_s1),
		.sect_s1      (sect_s1),
		.third_s1     (third_s1),
		.twothirds_s1 (twothirds_s1),
		.ctl_s1       (ctl_s1)
	);

	hsvr_hue u_hue (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.sect_s1      (sect_s1),
		.third_s1     (third_s1),
		.twothirds_s1 (twothirds_s1),
		.ctl_s1       (ctl_s1),
		.valid_s2     (valid_s2),
		.rgb_s2       (rgb_s2),
		.ctl_s2       (ctl_s2)
	);

	hsvr_sat u_sat (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.rgb_s2   (rgb_s2),
		.ctl_s2   (ctl_s2),
		.valid_s3 (valid_s3),
		.rgb_s3   (rgb_s3),
		.ctl_s3   (ctl_s3)
	);

	hsvr_val u_val (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.rgb_s3   (rgb_s3),
		.ctl_s3   (ctl_s3),
		.valid_s4 (valid_s4),
		.rgb_s4   (rgb_s4)
	);

	assign done  = valid_s4;
	assign red   = rgb_s4.r;
	assign green = rgb_s4.g;
	assign blue  = rgb_s4.b;

endmodule

FILE: tb/tb_hsv_rainbow_to_rgb.sv
`timescale 1ns / 1ps
// tb_hsv_rainbow_to_rgb: self-checking bench for the rainbow hsv to rgb converter
// runs a directed color table, then random pixels checked against a local color model
// depends on hsvr_pkg and hsv_rainbow_to_rgb

module tb_hsv_rainbow_to_rgb;
	import hsvr_pkg::*;

	localparam int RandWords  = 1580;
	localparam int QuietLimit = 2000;
	localparam int DirRows    = 23;

	typedef struct {
		logic [7:0] h;
		logic [7:0] s;
		logic [7:0] v;
		bit         typed;
		rgb_t       rgb;
	} color_row_t;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	logic [7:0] hue;
	logic [7:0] saturation;
	logic [7:0] brightness;
	logic       done;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	bit   cur_typed;
	rgb_t cur_rgb;
	rgb_t rgb_expected [$];
	int   mismatches;
	int   quiet_cycles;
	bit   gaps_on;

	// typed colors: pure section starts, white and black
	color_row_t color_rows [DirRows] = '{
		'{8'h00, 8'hFF, 8'hFF, 1'b1, 24'hFF_00_00},
		'{8'h20, 8'hFF, 8'hFF, 1'b1, {8'd171, 8'd85, 8'd0}},
		'{8'h40, 8'hFF, 8'hFF, 1'b1, {8'd171, 8'd170, 8'd0}},
		'{8'h60, 8'hFF, 8'hFF, 1'b1, {8'd0, 8'd255, 8'd0}},
		'{8'h80, 8'hFF, 8'hFF, 1'b1, {8'd0, 8'd171, 8'd85}},
		'{8'hA0, 8'hFF, 8'hFF, 1'b1, {8'd0, 8'd0, 8'd255}},
		'{8'hC0, 8'hFF, 8'hFF, 1'b1, {8'd85, 8'd0, 8'd171}},
		'{8'hE0, 8'hFF, 8'hFF, 1'b1, {8'd170, 8'd0, 8'd85}},
		'{8'h1F, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'h3F, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'h5F, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'h7F, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'h9F, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'hBF, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'hDF, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'hFF, 8'hFF, 8'hFF, 1'b0, 24'h0},
		'{8'h55, 8'h00, 8'hFF, 1'b1, 24'hFF_FF_FF},
		'{8'hAA, 8'h00, 8'h00, 1'b1, 24'h00_00_00},
		'{8'h00, 8'hFF, 8'h00, 1'b1, 24'h00_00_00},
		'{8'hFF, 8'h01, 8'h01, 1'b0, 24'h0},
		'{8'h80, 8'hFE, 8'hFE, 1'b0, 24'h0},
		'{8'h00, 8'h80, 8'hFF, 1'b0, 24'h0},
		'{8'hCC, 8'hAA, 8'h55, 1'b0, 24'h0}
	};

	hsv_rainbow_to_rgb i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.hue       (hue),
		.saturation(saturation),
		.brightness(brightness),
		.done      (done),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [7:0] scale8(input logic [7:0] a, input logic [7:0] b);
		logic [15:0] prod;
		prod = a * b;
		return prod[15:8];
	endfunction

	function automatic logic [7:0] desat_chan(input logic [7:0] c, input logic [7:0] scale,
			input logic [7:0] lift);
		logic [7:0] x;
		x = c;
		if (x != 8'd0) begin
			x = scale8(x, scale) + 8'd1;
		end
		return x + lift;
	endfunction

	function automatic logic [7:0] dim_chan(input logic [7:0] c, input logic [7:0] scale);
		return (c == 8'd0) ? 8'd0 : scale8(c, scale) + 8'd1;
	endfunction

	function automatic rgb_t rainbow_color(input logic [7:0] h, input logic [7:0] s,
			input logic [7:0] v);
		logic [7:0] step8;
		logic [7:0] third;
		logic [7:0] two3;
		logic [7:0] desat;
		logic [7:0] satscale;
		logic [7:0] lift;
		logic [7:0] vscale;
		rgb_t       c;
		step8 = {h[4:0], 3'b000};
		third = scale8(step8, ThirdK);
		two3  = scale8(step8, TwoThirdK);
		case (sect_t'(h[7:5]))
			SEC_RED_ORANGE:    c = {ChMax - third, third, 8'd0};
			SEC_ORANGE_YELLOW: c = {Lvl171, Lvl85 + third, 8'd0};
			SEC_YELLOW_GREEN:  c = {Lvl171 - two3, Lvl170 + third, 8'd0};
			SEC_GREEN_AQUA:    c = {8'd0, ChMax - third, third};
			SEC_AQUA_BLUE:     c = {8'd0, Lvl171 - two3, Lvl85 + two3};
			SEC_BLUE_PURPLE:   c = {third, 8'd0, ChMax - third};
			SEC_PURPLE_PINK:   c = {Lvl85 + third, 8'd0, Lvl171 - third};
			default:           c = {Lvl170 + third, 8'd0, Lvl85 - third};
		endcase
		if (s != ChMax) begin
			if (s == 8'd0) begin
				c = {ChMax, ChMax, ChMax};
			end else begin
				desat    = ChMax - s;
				satscale = ChMax - scale8(desat, desat);
				lift     = ChMax - satscale;
				c.r = desat_chan(c.r, satscale, lift);
				c.g = desat_chan(c.g, satscale, lift);
				c.b = desat_chan(c.b, satscale, lift);
			end
		end
		if (v != ChMax) begin
			if (v == 8'd0) begin
				c = '0;
			end else begin
				vscale = scale8(v, v);
				c.r = dim_chan(c.r, vscale);
				c.g = dim_chan(c.g, vscale);
				c.b = dim_chan(c.b, vscale);
			end
		end
		return c;
	endfunction

	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	// result check and word capture, both at the rising edge
	always @(posedge clk) begin
		rgb_t want;
		if (arst_n) begin
			if (done) begin
				if (rgb_expected.size() == 0) begin
					report_mismatch($sformatf("color %0d,%0d,%0d with nothing expected",
						red, green, blue));
				end else begin
					want = rgb_expected.pop_front();
					if (red !== want.r)
						report_mismatch($sformatf("red want %0d got %0d", want.r, red));
					if (green !== want.g)
						report_mismatch($sformatf("green want %0d got %0d", want.g, green));
					if (blue !== want.b)
						report_mismatch($sformatf("blue want %0d got %0d", want.b, blue));
				end
			end
			if (start && !busy) begin
				rgb_expected.push_back(cur_typed ? cur_rgb
					: rainbow_color(hue, saturation, brightness));
			end
			if (done || (start && !busy))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		wait (quiet_cycles >= QuietLimit);
		$display("status: fail");
		$finish;
	end

	// called at a falling edge, returns at the falling edge after the word is taken
	task automatic send_word(input logic [7:0] h, input logic [7:0] s, input logic [7:0] v,
			input bit typed, input rgb_t rgb);
		while (gaps_on && $urandom_range(0, 99) < 8) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start      <= 1'b1;
		hue        <= h;
		saturation <= s;
		brightness <= v;
		cur_typed  <= typed;
		cur_rgb    <= rgb;
		do begin
			@(posedge clk);
		end while (busy);
		@(negedge clk);
	endtask

	task automatic drain_colors();
		start <= 1'b0;
		@(negedge clk);
		while (rgb_expected.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		mismatches   = 0;
		quiet_cycles = 0;
		gaps_on      = 1'b1;
		arst_n       = 1'b0;
		start        = 1'b0;
		hue          = 8'd0;
		saturation   = 8'd0;
		brightness   = 8'd0;
		cur_typed    = 1'b0;
		cur_rgb      = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (color_rows[i])
			send_word(color_rows[i].h, color_rows[i].s, color_rows[i].v,
				color_rows[i].typed, color_rows[i].rgb);

		for (int n = 0; n < RandWords; n++) begin
			gaps_on = !(n >= 300 && n < 700);
			if (n == 800)
				drain_colors();
			send_word(8'($urandom_range(0, 255)), pick_level(), pick_level(), 1'b0, '0);
		end

		start <= 1'b0;
		while (rgb_expected.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (rgb_expected.size() != 0)
			report_mismatch($sformatf("%0d colors never arrived", rgb_expected.size()));
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
